### rtl/core/avr_subset_instruction_executor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the instruction executor
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AVR_SUBSET_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH
`define AVR_SUBSET_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define AVREX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AVREX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/avrex_pkg.sv
// ----------------------------------------------------------------------------
// avrex_pkg
// Opcode patterns, decode function and shared types of the executor.
// ----------------------------------------------------------------------------
package avrex_pkg;

  localparam int unsigned PcBitsDefault = 14;
  localparam int unsigned OutPcBits     = 14;
  localparam int unsigned RegAddrBits   = 5;
  localparam int unsigned RegDepth      = 32;

  localparam logic [15:0] JmpMask  = 16'hfe0e;
  localparam logic [15:0] JmpPat   = 16'h940c;
  localparam logic [15:0] EorMask  = 16'hfc00;
  localparam logic [15:0] EorPat   = 16'h2400;
  localparam logic [15:0] OutMask  = 16'hf800;
  localparam logic [15:0] OutPat   = 16'hb800;
  localparam logic [15:0] NibMask  = 16'hf000;
  localparam logic [15:0] LdiPat   = 16'he000;
  localparam logic [15:0] RjmpPat  = 16'hc000;
  localparam logic [15:0] CpiPat   = 16'h3000;
  localparam logic [15:0] CpcMask  = 16'hfc00;
  localparam logic [15:0] CpcPat   = 16'h0400;

  localparam logic [5:0]  StatusIoAddr = 6'h3f;

  typedef enum logic [2:0] {
    OP_JMP,
    OP_EOR,
    OP_OUT,
    OP_LDI,
    OP_RJMP,
    OP_CPI,
    OP_CPC,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [OutPcBits-1:0]   next_pc;
    logic [7:0]             status_out;
    logic                   io_write;
    logic [5:0]             io_addr;
    logic [7:0]             io_data;
    logic                   reg_write;
    logic [RegAddrBits-1:0] reg_addr;
    logic [7:0]             reg_data;
    logic [1:0]             words_used;
    logic                   unknown_op;
  } result_t;

  typedef struct packed {
    logic                   en;
    logic [RegAddrBits-1:0] addr;
    logic [7:0]             data;
  } wr_t;

  // No pattern overlaps another, so the order of the checks does not change the result.
  function automatic op_e avrex_decode(logic [15:0] w);
    op_e op;
    priority if ((w & JmpMask) == JmpPat)  op = OP_JMP;
    else if ((w & EorMask) == EorPat)      op = OP_EOR;
    else if ((w & OutMask) == OutPat)      op = OP_OUT;
    else if ((w & NibMask) == LdiPat)      op = OP_LDI;
    else if ((w & NibMask) == RjmpPat)     op = OP_RJMP;
    else if ((w & NibMask) == CpiPat)      op = OP_CPI;
    else if ((w & CpcMask) == CpcPat)      op = OP_CPC;
    else                                   op = OP_NONE;
    return op;
  endfunction

endpackage

### rtl/core/avrex_channels.sv
// ----------------------------------------------------------------------------
// avrex channels
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface avrex_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_word;
  logic [15:0] second_word;

  modport source (output valid, output first_word, output second_word, input ready);
  modport sink   (input valid, input first_word, input second_word, output ready);
endinterface

interface avrex_out_if;
  import avrex_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OutPcBits-1:0]   next_pc;
  logic [7:0]             status_out;
  logic                   io_write;
  logic [5:0]             io_addr;
  logic [7:0]             io_data;
  logic                   reg_write;
  logic [RegAddrBits-1:0] reg_addr;
  logic [7:0]             reg_data;
  logic [1:0]             words_used;
  logic                   unknown_op;

  modport source (output valid, output next_pc, output status_out, output io_write,
                  output io_addr, output io_data, output reg_write, output reg_addr,
                  output reg_data, output words_used, output unknown_op, input ready);
  modport sink   (input valid, input next_pc, input status_out, input io_write,
                  input io_addr, input io_data, input reg_write, input reg_addr,
                  input reg_data, input words_used, input unknown_op, output ready);
endinterface

### rtl/core/avrex_regfile.sv
// ----------------------------------------------------------------------------
// avrex_regfile
// 32 x 8 general registers: two registered read ports, one write port,
// per-entry valid bits for the zero reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
module avrex_regfile (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [avrex_pkg::RegAddrBits-1:0] rd_addr_a_i,
  input  logic [avrex_pkg::RegAddrBits-1:0] rd_addr_b_i,
  input  avrex_pkg::wr_t                   wr_i,
  output logic [7:0]                       rd_data_a_o,
  output logic [7:0]                       rd_data_b_o
);
  import avrex_pkg::*;

  logic [7:0]          mem_q [RegDepth];
  logic [RegDepth-1:0] valid_q;
  logic [7:0]          ra_q, rb_q, fwd_q;
  logic                va_q, vb_q, hit_a_q, hit_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      ra_q  <= mem_q[rd_addr_a_i];
      rb_q  <= mem_q[rd_addr_b_i];
      fwd_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        va_q    <= valid_q[rd_addr_a_i];
        vb_q    <= valid_q[rd_addr_b_i];
        // memory returns old data on a same-edge write: catch it here
        hit_a_q <= wr_i.en && (wr_i.addr == rd_addr_a_i);
        hit_b_q <= wr_i.en && (wr_i.addr == rd_addr_b_i);
      end
    end
  end

  assign rd_data_a_o = hit_a_q ? fwd_q : (va_q ? ra_q : 8'h00);
  assign rd_data_b_o = hit_b_q ? fwd_q : (vb_q ? rb_q : 8'h00);

endmodule

### rtl/core/avrex_exec.sv
// ----------------------------------------------------------------------------
// avrex_exec
// Decode and execute one instruction against operands, status and counter.
// ----------------------------------------------------------------------------
module avrex_exec #(
  parameter int unsigned PC_BITS = avrex_pkg::PcBitsDefault
) (
  input  logic [15:0]          first_word_i,
  input  logic [15:0]          second_word_i,
  input  logic [7:0]           rd_a_i,
  input  logic [7:0]           rd_b_i,
  input  logic [7:0]           status_i,
  input  logic [PC_BITS-1:0]   pc_i,
  output logic [7:0]           status_o,
  output logic [PC_BITS-1:0]   pc_o,
  output avrex_pkg::result_t   res_o
);
  import avrex_pkg::*;

  localparam int unsigned WideBits = (PC_BITS > OutPcBits) ? PC_BITS : OutPcBits;

  op_e              op;
  logic [PC_BITS-1:0] pc_plus1;
  logic [21:0]      jmp_tgt;
  logic [21:0]      rjmp_off;
  logic [7:0]       imm8;
  logic [8:0]       diff;
  logic [5:0]       io_a;
  logic [WideBits-1:0] pc_wide;

  assign op       = avrex_decode(first_word_i);
  assign pc_plus1 = pc_i + PC_BITS'(1);
  assign jmp_tgt  = {first_word_i[8:4], first_word_i[0], second_word_i};
  assign rjmp_off = {{10{first_word_i[11]}}, first_word_i[11:0]};
  assign imm8     = {first_word_i[11:8], first_word_i[3:0]};
  assign io_a     = {first_word_i[10:9], first_word_i[3:0]};

  always_comb begin
    res_o      = '0;
    res_o.words_used = 2'd1;
    status_o   = status_i;
    pc_o       = pc_plus1;
    diff       = '0;
    unique case (op)
      OP_JMP: begin
        pc_o = jmp_tgt[PC_BITS-1:0];
        res_o.words_used = 2'd2;
      end
      OP_EOR: begin
        res_o.reg_write = 1'b1;
        res_o.reg_addr  = first_word_i[8:4];
        res_o.reg_data  = rd_a_i ^ rd_b_i;
      end
      OP_OUT: begin
        res_o.io_write = 1'b1;
        res_o.io_addr  = io_a;
        res_o.io_data  = rd_a_i;
        if (io_a == StatusIoAddr) begin
          status_o = rd_a_i;
        end
      end
      OP_LDI: begin
        res_o.reg_write = 1'b1;
        res_o.reg_addr  = {1'b1, first_word_i[7:4]};
        res_o.reg_data  = imm8;
      end
      OP_RJMP: begin
        pc_o = pc_plus1 + rjmp_off[PC_BITS-1:0];
      end
      OP_CPI: begin
        diff     = {1'b0, rd_a_i} - {1'b0, imm8};
        status_o = {status_i[7:2], diff[7:0] == 8'h00, diff[8]};
      end
      OP_CPC: begin
        diff     = {1'b0, rd_a_i} - {1'b0, rd_b_i} - {8'h00, status_i[0]};
        // zero chains: stays set only if it was already set
        status_o = {status_i[7:2], (diff[7:0] == 8'h00) && status_i[1], diff[8]};
      end
      OP_NONE: begin
        res_o.unknown_op = 1'b1;
      end
      default: begin
        res_o.unknown_op = 1'b1;
      end
    endcase
    pc_wide          = WideBits'(pc_o);
    res_o.next_pc    = pc_wide[OutPcBits-1:0];
    res_o.status_out = status_o;
  end

endmodule

### rtl/core/avr_subset_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// avr_subset_instruction_executor_unit
// Executes one instruction of a small 8-bit microcontroller subset per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i carries one instruction beat: the word at the program counter
//   and the word after it (the latter only matters for JMP). out_ch_o
//   returns one result beat per instruction: the new counter, the status
//   register and the register or I/O write that the instruction made.
//   Beats pass the execute stage, then the output register. A new beat is
//   taken every cycle unless stalled; the register file is a synchronous
//   memory read at the accept edge and written back when the instruction
//   retires, so a result that depends on the previous instruction's write
//   is served by a forwarding register in the register file. Reset clears
//   the counter, the status register and all 32 general registers (through
//   per-entry valid bits, no clearing pass). When the receiver stalls, the
//   result waits in the output register, one more instruction waits in
//   the execute stage, and then in_ch_i.ready drops.
// ----------------------------------------------------------------------------
`include "avr_subset_instruction_executor_unit_macros.svh"

module avr_subset_instruction_executor_unit #(
  parameter int unsigned PC_BITS = avrex_pkg::PcBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  avrex_in_if.sink     in_ch_i,
  avrex_out_if.source  out_ch_o
);
  import avrex_pkg::*;

  // execute stage
  logic               s1_valid_q;
  logic [15:0]        s1_w1_q, s1_w2_q;
  logic               s1_advance;
  logic               in_accept;

  // architectural state
  logic [7:0]         status_q;
  logic [PC_BITS-1:0] pc_q;

  // output register
  logic               out_valid_q;
  result_t            out_q;

  logic [RegAddrBits-1:0] rd_addr_a, rd_addr_b;
  logic [7:0]         rd_a, rd_b;
  logic [7:0]         exec_status;
  logic [PC_BITS-1:0] exec_pc;
  result_t            exec_res;
  wr_t                wr;

  // Advance the execute stage when the output register is free or drains.
  assign s1_advance      = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready   = !s1_valid_q || s1_advance;
  assign in_accept       = in_ch_i.valid && in_ch_i.ready;

  // Operand addresses come straight from the incoming word; CPI uses the
  // upper-half register field, everything else the five-bit d field.
  assign rd_addr_a = (avrex_decode(in_ch_i.first_word) == OP_CPI) ?
                     {1'b1, in_ch_i.first_word[7:4]} : in_ch_i.first_word[8:4];
  assign rd_addr_b = {in_ch_i.first_word[9], in_ch_i.first_word[3:0]};

  // Write back only when the instruction retires.
  assign wr.en   = s1_advance && exec_res.reg_write;
  assign wr.addr = exec_res.reg_addr;
  assign wr.data = exec_res.reg_data;

  avrex_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_accept),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .wr_i        (wr),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  avrex_exec #(
    .PC_BITS (PC_BITS)
  ) u_exec (
    .first_word_i  (s1_w1_q),
    .second_word_i (s1_w2_q),
    .rd_a_i        (rd_a),
    .rd_b_i        (rd_b),
    .status_i      (status_q),
    .pc_i          (pc_q),
    .status_o      (exec_status),
    .pc_o          (exec_pc),
    .res_o         (exec_res)
  );

  // Hold instruction words in the execute stage until retire.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_w1_q <= in_ch_i.first_word;
      s1_w2_q <= in_ch_i.second_word;
    end
    if (s1_advance) begin
      out_q <= exec_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      pc_q        <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
        status_q    <= exec_status;
        pc_q        <= exec_pc;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.next_pc    = out_q.next_pc;
  assign out_ch_o.status_out = out_q.status_out;
  assign out_ch_o.io_write   = out_q.io_write;
  assign out_ch_o.io_addr    = out_q.io_addr;
  assign out_ch_o.io_data    = out_q.io_data;
  assign out_ch_o.reg_write  = out_q.reg_write;
  assign out_ch_o.reg_addr   = out_q.reg_addr;
  assign out_ch_o.reg_data   = out_q.reg_data;
  assign out_ch_o.words_used = out_q.words_used;
  assign out_ch_o.unknown_op = out_q.unknown_op;

  // A retiring instruction always lands in the output register.
  `AVREX_ASSERT_NEXT(a_retire_fills_out, s1_advance, out_valid_q, "retire lost")
  // The status register seen downstream matches the committed one.
  `AVREX_ASSERT_NEXT(a_status_commit, s1_advance, out_q.status_out == status_q,
                     "status mismatch")
  // An unknown word makes no register or I/O write.
  `AVREX_ASSERT_NOW(a_unknown_quiet, out_valid_q && out_q.unknown_op,
                    !out_q.reg_write && !out_q.io_write, "unknown op wrote state")
  // A two-word JMP writes nothing and is never flagged unknown.
  `AVREX_ASSERT_NOW(a_jmp_quiet, out_valid_q && (out_q.words_used == 2'd2),
                    !out_q.reg_write && !out_q.io_write && !out_q.unknown_op,
                    "jmp with side effect")

endmodule
